// File: design/cfcg_pkg.sv
// ============================================================================
// CRC folding constant generator package
// Shared types, constants and bit helpers for the folding constant generator.
// ============================================================================
package cfcg_pkg;

    localparam int unsigned POLY_DEGREE = 32;
    localparam int unsigned CNT_W       = 10;

    localparam int unsigned N_FOLD_4X_REFL_LO = 4 * 128 - 32;
    localparam int unsigned N_FOLD_4X_REFL_HI = 4 * 128 + 32;
    localparam int unsigned N_FOLD_1X_REFL_LO = 128 - 32;
    localparam int unsigned N_FOLD_1X_REFL_HI = 128 + 32;
    localparam int unsigned N_FOLD_4X_HI      = 4 * 128 + 64;
    localparam int unsigned N_FOLD_4X_LO      = 4 * 128;
    localparam int unsigned N_FOLD_1X_HI      = 128 + 64;
    localparam int unsigned N_FOLD_1X_LO      = 128;
    localparam int unsigned N_REDUCE_64       = 64;
    localparam int unsigned N_REDUCE_96       = 96;

    localparam logic [CNT_W-1:0] LAST_SHIFT = CNT_W'(N_FOLD_4X_HI - POLY_DEGREE);

    localparam logic [5:0] WIDTH_MIN = 6'd8;
    localparam logic [5:0] WIDTH_MAX = 6'd32;

    localparam logic [2:0] IDX_QUOTIENT = 3'd6;
    localparam logic [2:0] IDX_POLY     = 3'd7;

    typedef struct packed {
        logic        reflected;
        logic [5:0]  crc_width;
        logic [31:0] polynomial;
    } req_t;

    typedef struct packed {
        logic [2:0]  constant_index;
        logic [32:0] constant_value;
        logic        bad_request;
        logic        last;
    } res_t;

    typedef struct packed {
        logic             fresh;
        logic             done;
        logic [CNT_W-1:0] count;
        logic [31:0]      rem;
        logic [32:0]      quo;
    } step_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } state_t;

    function automatic logic [31:0] rev32(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[i] = v[31-i];
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] shift_of(input int unsigned n);
        return CNT_W'(n - POLY_DEGREE);
    endfunction

    // Number of shift steps after which constant idx is captured.
    function automatic logic [CNT_W-1:0] shift_target(input logic refl, input logic [2:0] idx);
        logic [CNT_W-1:0] t;
        unique case (idx)
            3'd0:    t = refl ? shift_of(N_FOLD_4X_REFL_LO) : shift_of(N_FOLD_4X_HI);
            3'd1:    t = refl ? shift_of(N_FOLD_4X_REFL_HI) : shift_of(N_FOLD_4X_LO);
            3'd2:    t = refl ? shift_of(N_FOLD_1X_REFL_LO) : shift_of(N_FOLD_1X_HI);
            3'd3:    t = refl ? shift_of(N_FOLD_1X_REFL_HI) : shift_of(N_FOLD_1X_LO);
            3'd4:    t = refl ? shift_of(N_FOLD_1X_REFL_LO) : shift_of(N_REDUCE_64);
            3'd5:    t = refl ? shift_of(N_REDUCE_64) : shift_of(N_REDUCE_96);
            3'd6:    t = shift_of(N_REDUCE_64);
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [32:0] fold_rem(input logic refl, input logic [31:0] rem);
        return refl ? {rev32(rem), 1'b0} : {1'b0, rem};
    endfunction

    function automatic logic [32:0] fold_quo(input logic refl, input logic [32:0] quo);
        return refl ? {rev32(quo[31:0]), 1'b0} : quo;
    endfunction

endpackage

// File: design/cfcg_shift_unit.sv
// ============================================================================
// CRC folding constant shift unit
// GF(2) shift-xor engine that steps x^n mod P upward one degree per cycle.
// ============================================================================
module cfcg_shift_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [31:0]    poly,
    output cfcg_pkg::step_t step
);
    import cfcg_pkg::*;

    logic             busy_reg;
    logic             busy_next;
    logic             fresh_reg;
    logic             fresh_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [31:0]      rem_reg;
    logic [31:0]      rem_next;
    logic [32:0]      quo_reg;
    logic [32:0]      quo_next;
    logic [31:0]      p_reg;
    logic [31:0]      p_next;
    logic             hi;

    assign hi = rem_reg[31];

    always_comb
    begin
        busy_next  = busy_reg;
        fresh_next = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        p_next     = p_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = poly;
            quo_next  = 33'd1;
            p_next    = poly;
        end
        else if (busy_reg)
        begin
            fresh_next = 1'b1;
            cnt_next   = cnt_reg + 1'b1;
            rem_next   = {rem_reg[30:0], 1'b0} ^ (hi ? p_reg : 32'd0);
            quo_next   = {quo_reg[31:0], hi};
            if (cnt_next == LAST_SHIFT)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            fresh_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            fresh_reg <= fresh_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        p_reg   <= p_next;
    end

    assign step.fresh = fresh_reg;
    assign step.done  = fresh_reg && (cnt_reg == LAST_SHIFT);
    assign step.count = cnt_reg;
    assign step.rem   = rem_reg;
    assign step.quo   = quo_reg;

endmodule

// File: design/crc_fold_constant_generator.sv
// ============================================================================
// CRC folding constant generator
// Computes eight folding and Barrett constants for a carry-less CRC kernel.
// ============================================================================
// A valid item runs the shift-xor unit up to the last shift target; its results
// then follow one per cycle while res_stall does not hold them back.
// Items are handled one at a time by the single shift-xor unit; req_stall stays
// high until the last result is loaded. A rejected item gives its one result.
// Reset clears the sequencer and the output valid; no memory needs clearing.
module crc_fold_constant_generator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  cfcg_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_stall,
    output cfcg_pkg::res_t res
);
    import cfcg_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    logic        err_reg;
    logic        err_next;
    logic        refl_reg;
    logic        refl_next;
    logic        res_valid_reg;
    logic        res_valid_next;
    res_t        res_reg;
    res_t        res_next;
    logic [32:0] c_reg [8];

    logic        bad;
    logic [5:0]  shamt;
    logic [31:0] p_start;
    logic        accept;
    logic        start;
    logic        load;
    step_t       step;

    assign shamt   = 6'd32 - req.crc_width;
    assign bad     = (req.crc_width < WIDTH_MIN) || (req.crc_width > WIDTH_MAX)
                     || (({1'b0, req.polynomial} >> req.crc_width) != 33'd0);
    assign p_start = req.reflected ? rev32(req.polynomial) : (req.polynomial << shamt);

    cfcg_shift_unit u_shift (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .poly  (p_start),
        .step  (step)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = bad ? ST_EMIT : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load && (err_reg || (idx_reg == IDX_POLY)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        accept         = (state_reg == ST_IDLE) && req_valid;
        start          = accept && !bad;
        load           = (state_reg == ST_EMIT) && (!res_valid_reg || !res_stall);
        idx_next       = idx_reg;
        err_next       = err_reg;
        refl_next      = refl_reg;
        res_next       = res_reg;
        res_valid_next = res_stall ? res_valid_reg : 1'b0;
        if (accept)
        begin
            idx_next  = '0;
            err_next  = bad;
            refl_next = req.reflected;
        end
        if (load)
        begin
            res_valid_next = 1'b1;
            idx_next       = idx_reg + 1'b1;
            if (err_reg)
            begin
                res_next.constant_index = '0;
                res_next.constant_value = '0;
                res_next.bad_request    = 1'b1;
                res_next.last           = 1'b1;
            end
            else
            begin
                res_next.constant_index = idx_reg;
                res_next.constant_value = c_reg[idx_reg];
                res_next.bad_request    = 1'b0;
                res_next.last           = (idx_reg == IDX_POLY);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            err_reg       <= 1'b0;
            refl_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            err_reg       <= err_next;
            refl_reg      <= refl_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (start)
        begin
            c_reg[IDX_POLY] <= req.reflected ? {rev32(p_start), 1'b1} : {1'b1, p_start};
        end
        if ((state_reg == ST_RUN) && step.fresh)
        begin
            for (int k = 0; k < 7; k++)
            begin
                if (step.count == shift_target(refl_reg, 3'(k)))
                begin
                    c_reg[k] <= (3'(k) == IDX_QUOTIENT) ? fold_quo(refl_reg, step.quo)
                                                        : fold_rem(refl_reg, step.rem);
                end
            end
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
